/* sv/kcr_pkg.sv */
// Package for the keystream character rotate cipher.
// Holds the generator and character constants, register indexes and shared types.
// No dependencies.
package kcr_pkg;

    localparam int unsigned CharW  = 7;
    localparam int unsigned SeedW  = 16;
    localparam int unsigned GenW   = 17;
    localparam int unsigned MultW  = 7;
    localparam int unsigned ProdW  = GenW + MultW;
    localparam int unsigned CfgAddrW = 1;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned TdataW = 8;

    localparam logic [MultW-1:0] GEN_MULT   = 7'd75;
    localparam logic [GenW-1:0]  GEN_MOD    = 17'd65537;
    localparam logic [GenW-1:0]  GEN_MAX    = 17'd65536;
    localparam logic [GenW-1:0]  GEN_RESET  = 17'd1;
    localparam logic [SeedW-1:0] SEED_RESET = 16'd1;
    localparam logic [CharW-1:0] PRINT_BASE = 7'd32;
    localparam logic [CharW:0]   PRINT_SPAN = 8'd96;

    typedef enum logic [CfgAddrW-1:0] {
        REG_CIPHER_MODE = 1'b0,
        REG_SEED_INIT   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic advance;
        logic restart;
    } t_gen_ctrl;

    // Residue modulo 3 of a 12-bit value, using 4 = 1 (mod 3) on base-4 digits.
    function automatic logic [1:0] mod3_12(input logic [11:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] r;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            r = t - 3'd6;
        end else if (t >= 3'd3) begin
            r = t - 3'd3;
        end else begin
            r = t;
        end
        return r[1:0];
    endfunction

endpackage

/* sv/keystream_char_rotate_cipher_core.sv */
// Top level of the keystream character rotate cipher.
// Depends on kcr_pkg, kcr_keygen and kcr_rotate.
//
// Usage:
// Characters enter on the slave stream: tdata carries the 7-bit character,
// tuser the start-of-stream flag, which reloads the generator from the seed
// register before that item's step. Every item yields exactly one result
// item on the master stream, whose tdata carries the transformed character.
// The generator advances on every item, control characters included.
// The generator step is registered with the item in the first stage, and
// the rotation by the key is registered in the output register. One item
// per cycle is taken as long as results are drained; the generator's
// multiply-and-reduce loop sets that rate.
// When the receiver stalls, the output register holds its result and the
// first stage still accepts one more item; then tready drops.
// The configuration port writes cipher mode (index 0) and seed (index 1)
// and must be used only while the block is idle, which it does not enforce.
// Reset clears both stages, sets the mode to encrypt, the seed to one and
// the generator to one.
module keystream_char_rotate_cipher_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [kcr_pkg::TdataW-1:0]     i_s_tdata,   // [6:0] in_char, [7] zero
    input  logic                           i_s_tuser,   // [0] start_of_stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [kcr_pkg::TdataW-1:0]     o_m_tdata,   // [6:0] out_char, [7] zero
    input  logic                           i_cfg_we,
    input  logic [kcr_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  logic [kcr_pkg::CfgDataW-1:0]   i_cfg_wdata
);

    logic                        r_cipher_mode;
    logic [kcr_pkg::SeedW-1:0]   r_seed_init;
    logic                        r_s1_valid;
    logic [kcr_pkg::CharW-1:0]   r_s1_char;
    logic                        r_out_valid;
    logic [kcr_pkg::CharW-1:0]   r_out_char;
    logic                        out_free;
    logic                        in_accept;
    logic [kcr_pkg::GenW-1:0]    gen_value;
    logic [kcr_pkg::CharW-1:0]   rot_char;
    kcr_pkg::t_gen_ctrl          gen_ctrl;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || out_free;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_comb begin
        gen_ctrl.advance = in_accept;
        gen_ctrl.restart = i_s_tuser;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_mode <= 1'b0;
            r_seed_init   <= kcr_pkg::SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                kcr_pkg::REG_CIPHER_MODE: r_cipher_mode <= i_cfg_wdata[0];
                kcr_pkg::REG_SEED_INIT:   r_seed_init   <= i_cfg_wdata[kcr_pkg::SeedW-1:0];
                default: ;
            endcase
        end
    end

    kcr_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (gen_ctrl),
        .i_seed  (r_seed_init),
        .o_value (gen_value)
    );

    kcr_rotate u_rotate (
        .i_char    (r_s1_char),
        .i_key     (gen_value),
        .i_decrypt (r_cipher_mode),
        .o_char    (rot_char)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char <= i_s_tdata[kcr_pkg::CharW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_char <= rot_char;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = kcr_pkg::TdataW'(r_out_char);

    // A pending first-stage item moves into an empty output register.
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !r_out_valid |=> r_out_valid)
        else $error("first-stage item did not reach the output register");

    // Both stages full and stalled: no further item may be taken.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_m_tready |-> !o_s_tready)
        else $error("item accepted while both stages are full");

    // The generator moves only when an item is accepted.
    a_gen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(gen_value))
        else $error("generator changed without an accepted item");

    // The generator residue never leaves the range of the modulus.
    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_value <= kcr_pkg::GEN_MAX)
        else $error("generator value out of range");

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

endmodule

/* sv/kcr_keygen.sv */
// Lehmer keystream generator: value <= value * 75 mod 65537, reloadable from the seed.
// Depends on kcr_pkg.
module kcr_keygen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kcr_pkg::t_gen_ctrl          i_ctrl,
    input  logic [kcr_pkg::SeedW-1:0]   i_seed,
    output logic [kcr_pkg::GenW-1:0]   o_value
);

    logic [kcr_pkg::GenW-1:0]  r_gen;
    logic [kcr_pkg::GenW-1:0]  n_gen;
    logic [kcr_pkg::GenW-1:0]  base;
    logic [kcr_pkg::ProdW-1:0] prod;
    logic [kcr_pkg::GenW:0]    diff;

    // Since 65536 = -1 (mod 65537), the residue is low half minus high half.
    always_comb begin
        base = i_ctrl.restart ? kcr_pkg::GenW'(i_seed) : r_gen;
        prod = kcr_pkg::ProdW'(base) * kcr_pkg::ProdW'(kcr_pkg::GEN_MULT);
        diff = (kcr_pkg::GenW+1)'(prod[15:0]) - (kcr_pkg::GenW+1)'(prod[kcr_pkg::ProdW-1:16]);
        if (diff[kcr_pkg::GenW]) begin
            diff = diff + (kcr_pkg::GenW+1)'(kcr_pkg::GEN_MOD);
        end
        n_gen = diff[kcr_pkg::GenW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= kcr_pkg::GEN_RESET;
        end else if (i_ctrl.advance) begin
            r_gen <= n_gen;
        end
    end

    assign o_value = r_gen;

endmodule

/* sv/kcr_rotate.sv */
// Rotation of a printable character inside the 96-character window by key mod 96.
// Depends on kcr_pkg.
module kcr_rotate (
    input  logic [kcr_pkg::CharW-1:0] i_char,
    input  logic [kcr_pkg::GenW-1:0]  i_key,
    input  logic                      i_decrypt,
    output logic [kcr_pkg::CharW-1:0] o_char
);

    logic [kcr_pkg::CharW-1:0] shift;
    logic [kcr_pkg::CharW-1:0] pos;
    logic [kcr_pkg::CharW:0]   sum;

    always_comb begin
        // 96 = 3 * 32, so key mod 96 is (key / 32 mod 3) * 32 plus the low five bits.
        shift = {kcr_pkg::mod3_12(i_key[16:5]), i_key[4:0]};
        pos   = i_char - kcr_pkg::PRINT_BASE;
        if (i_decrypt) begin
            sum = (kcr_pkg::CharW+1)'(pos) + kcr_pkg::PRINT_SPAN - (kcr_pkg::CharW+1)'(shift);
        end else begin
            sum = (kcr_pkg::CharW+1)'(pos) + (kcr_pkg::CharW+1)'(shift);
        end
        if (sum >= kcr_pkg::PRINT_SPAN) begin
            sum = sum - kcr_pkg::PRINT_SPAN;
        end
        if (i_char < kcr_pkg::PRINT_BASE) begin
            o_char = i_char;
        end else begin
            o_char = sum[kcr_pkg::CharW-1:0] + kcr_pkg::PRINT_BASE;
        end
    end

endmodule
